// ----- rtl/core/lifegs_pkg.sv -----
// Shared types, cell codes and neighbor tables for the life grid block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package lifegs_pkg;

  localparam logic [2:0] CELL_EMPTY    = 3'd0;
  localparam logic [2:0] CELL_SURVIVED = 3'd1;
  localparam logic [2:0] CELL_BORN     = 3'd2;
  localparam logic [2:0] CELL_DIED     = 3'd3;
  localparam logic [2:0] CELL_FROM_XM  = 3'd4;
  localparam logic [2:0] CELL_FROM_XP  = 3'd5;
  localparam logic [2:0] CELL_FROM_YM  = 3'd6;
  localparam logic [2:0] CELL_FROM_YP  = 3'd7;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam logic [3:0] P1_LAST = 4'd9;
  localparam logic [3:0] P2_LAST = 4'd5;
  localparam logic [3:0] P3_LAST = 4'd1;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_CLR,
    MODE_OP,
    MODE_P1,
    MODE_P2,
    MODE_P3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] step;
    logic       accept;
    logic       cell_next;
    logic       cell_rst;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic p2_done;
    logic clr_last;
  } status_t;

  // Offsets 0, 1, 2 stand for -1, 0, +1.
  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
  } offs_t;

  function automatic logic is_live(input logic [2:0] s);
    return (s == CELL_SURVIVED) || (s == CELL_BORN) || s[2];
  endfunction

  function automatic offs_t p1_offs(input logic [3:0] s);
    offs_t o;
    case (s)
      4'd0: o = '{dx: 2'd0, dy: 2'd0};
      4'd1: o = '{dx: 2'd0, dy: 2'd1};
      4'd2: o = '{dx: 2'd0, dy: 2'd2};
      4'd3: o = '{dx: 2'd1, dy: 2'd0};
      4'd4: o = '{dx: 2'd1, dy: 2'd1};
      4'd5: o = '{dx: 2'd1, dy: 2'd2};
      4'd6: o = '{dx: 2'd2, dy: 2'd0};
      4'd7: o = '{dx: 2'd2, dy: 2'd1};
      4'd8: o = '{dx: 2'd2, dy: 2'd2};
      default: o = '{dx: 2'd1, dy: 2'd1};
    endcase
    return o;
  endfunction

  // Source search order: x-1, y-1, y+1, x+1.
  function automatic offs_t p2_offs(input logic [1:0] k);
    offs_t o;
    case (k)
      2'd0: o = '{dx: 2'd0, dy: 2'd1};
      2'd1: o = '{dx: 2'd1, dy: 2'd0};
      2'd2: o = '{dx: 2'd1, dy: 2'd2};
      2'd3: o = '{dx: 2'd2, dy: 2'd1};
      default: o = '{dx: 2'd1, dy: 2'd1};
    endcase
    return o;
  endfunction

  function automatic logic [2:0] p2_tag(input logic [1:0] k);
    logic [2:0] t;
    case (k)
      2'd0: t = CELL_FROM_XM;
      2'd1: t = CELL_FROM_YM;
      2'd2: t = CELL_FROM_YP;
      2'd3: t = CELL_FROM_XP;
      default: t = CELL_EMPTY;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lifegs_ctrl.sv -----
// Controller state machine of the life grid block: clearing sweep, operations
// and the three advance passes. Depends on lifegs_pkg.
`default_nettype none
module lifegs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_op,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output lifegs_pkg::cmd_t       cmd,
  input  wire lifegs_pkg::status_t sts
);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_OP, ST_P1, ST_P2, ST_P3, ST_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mode      = lifegs_pkg::MODE_NONE;
    cmd.step      = step_r;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_CLR: begin
        cmd.mode = lifegs_pkg::MODE_CLR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          step_nxt   = '0;
          if (in_op == lifegs_pkg::OP_ADVANCE) begin
            cmd.cell_rst = 1'b1;
            state_nxt    = ST_P1;
          end else if (in_op == lifegs_pkg::OP_WRITE || in_op == lifegs_pkg::OP_READ) begin
            state_nxt = ST_OP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_OP: begin
        cmd.mode  = lifegs_pkg::MODE_OP;
        state_nxt = ST_DONE;
      end
      ST_P1: begin
        cmd.mode = lifegs_pkg::MODE_P1;
        step_nxt = step_r + 4'd1;
        if (step_r == lifegs_pkg::P1_LAST) begin
          step_nxt = '0;
          if (sts.last_cell) begin
            cmd.cell_rst = 1'b1;
            state_nxt    = ST_P2;
          end else begin
            cmd.cell_next = 1'b1;
          end
        end
      end
      ST_P2: begin
        cmd.mode = lifegs_pkg::MODE_P2;
        step_nxt = step_r + 4'd1;
        if (sts.p2_done) begin
          step_nxt = '0;
          if (sts.last_cell) begin
            cmd.cell_rst = 1'b1;
            state_nxt    = ST_P3;
          end else begin
            cmd.cell_next = 1'b1;
          end
        end
      end
      ST_P3: begin
        cmd.mode = lifegs_pkg::MODE_P3;
        step_nxt = step_r + 4'd1;
        if (step_r == lifegs_pkg::P3_LAST) begin
          step_nxt = '0;
          if (sts.last_cell) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.cell_next = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLR)
    else $error("reset did not start the clearing sweep");
  a_adv_enters_p1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid && in_op == lifegs_pkg::OP_ADVANCE) |=> state_r == ST_P1)
    else $error("advance did not enter the first pass");
  a_p1_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_P1 |-> step_r <= lifegs_pkg::P1_LAST)
    else $error("first pass step out of range");
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> state_r == ST_DONE)
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire

// ----- rtl/core/lifegs_dp.sv -----
// Datapath of the life grid block: cell memories, size registers, raster
// counters, neighbor count and output register. Depends on lifegs_pkg.
`default_nettype none
module lifegs_dp #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lifegs_pkg::cmd_t    cmd,
  output lifegs_pkg::status_t      sts,
  input  wire logic [23:0]         in_tdata,
  output logic [7:0]               out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [6:0]          cfg_wdata
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int BW    = (DW > 7) ? DW : 7;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);

  logic [2:0] cur_mem [CELLS];
  logic [2:0] nxt_mem [CELLS];
  logic       tkn_mem [CELLS];

  logic [6:0]    cfg_w_r, cfg_h_r;
  logic [1:0]    op_r;
  logic [5:0]    x_in_r, y_in_r;
  logic [2:0]    ws_r;
  logic [CW-1:0] cx_r, cy_r;
  logic [AW-1:0] clr_r;
  logic [3:0]    cnt_r;
  logic          centre_r;
  logic [2:0]    cur_q, nxt_q;
  logic          tkn_q;
  logic [7:0]    out_r;

  logic [DW-1:0] effw, effh;
  logic          bad;
  logic [AW-1:0] c_addr, op_addr, p1_addr, p2r_addr, p2w_addr;
  logic [1:0]    rk, wk;
  logic          live_q, cand;
  logic [3:0]    n_tot;
  logic [2:0]    p1_val;

  function automatic logic [DW-1:0] eff_dim(input logic [6:0] v);
    logic [BW-1:0] e;
    e = BW'(v);
    if (e == '0) return DW'(1);
    if (e > BW'(MAX_DIM)) return DW'(MAX_DIM);
    return DW'(e);
  endfunction

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c, input logic [1:0] d,
                                         input logic [DW-1:0] dim);
    logic [CW-1:0] top;
    top = CW'(dim - DW'(1));
    case (d)
      2'd0: return (c == '0) ? top : c - CW'(1);
      2'd2: return (c == top) ? '0 : c + CW'(1);
      default: return c;
    endcase
  endfunction

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(AW'(x) * AW'(MAX_DIM) + AW'(y));
  endfunction

  function automatic logic [AW-1:0] nb_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input lifegs_pkg::offs_t o,
                                            input logic [DW-1:0] w, input logic [DW-1:0] h);
    return addr(wrap(x, o.dx, w), wrap(y, o.dy, h));
  endfunction

  always_comb begin
    effw     = eff_dim(cfg_w_r);
    effh     = eff_dim(cfg_h_r);
    bad      = (op_r == lifegs_pkg::OP_WRITE || op_r == lifegs_pkg::OP_READ) &&
               (BW'(x_in_r) >= BW'(effw) || BW'(y_in_r) >= BW'(effh));
    c_addr   = addr(cx_r, cy_r);
    op_addr  = addr(CW'(x_in_r), CW'(y_in_r));
    p1_addr  = nb_addr(cx_r, cy_r, lifegs_pkg::p1_offs(cmd.step), effw, effh);
    rk       = 2'(cmd.step - 4'd1);
    wk       = 2'(cmd.step - 4'd2);
    p2r_addr = nb_addr(cx_r, cy_r, lifegs_pkg::p2_offs(rk), effw, effh);
    p2w_addr = nb_addr(cx_r, cy_r, lifegs_pkg::p2_offs(wk), effw, effh);
    live_q   = lifegs_pkg::is_live(cur_q);
    n_tot    = cnt_r + {3'd0, live_q};
    if (centre_r) begin
      p1_val = (n_tot == 4'd2 || n_tot == 4'd3) ? lifegs_pkg::CELL_SURVIVED
                                                 : lifegs_pkg::CELL_DIED;
    end else begin
      p1_val = (n_tot == 4'd3) ? lifegs_pkg::CELL_BORN : lifegs_pkg::CELL_EMPTY;
    end
    cand = (nxt_q == lifegs_pkg::CELL_DIED) && !tkn_q && cmd.step >= 4'd2;
    sts.last_cell = (cx_r == CW'(effw - DW'(1))) && (cy_r == CW'(effh - DW'(1)));
    sts.clr_last  = (clr_r == AW'(CELLS - 1));
    sts.p2_done   = (cmd.step == 4'd1 && nxt_q != lifegs_pkg::CELL_BORN) || cand ||
                    cmd.step == lifegs_pkg::P2_LAST;
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    case (cmd.mode)
      lifegs_pkg::MODE_CLR: cur_mem[clr_r] <= lifegs_pkg::CELL_EMPTY;
      lifegs_pkg::MODE_OP: begin
        if (op_r == lifegs_pkg::OP_WRITE && !bad) cur_mem[op_addr] <= ws_r;
        if (op_r == lifegs_pkg::OP_READ) cur_q <= cur_mem[op_addr];
      end
      lifegs_pkg::MODE_P1: begin
        if (cmd.step <= 4'd8) cur_q <= cur_mem[p1_addr];
        if (cmd.step == lifegs_pkg::P1_LAST) begin
          nxt_mem[c_addr] <= p1_val;
          tkn_mem[c_addr] <= 1'b0;
        end
      end
      lifegs_pkg::MODE_P2: begin
        if (cmd.step == 4'd0) begin
          nxt_q <= nxt_mem[c_addr];
        end else if (cmd.step <= 4'd4) begin
          nxt_q <= nxt_mem[p2r_addr];
          tkn_q <= tkn_mem[p2r_addr];
        end
        if (cand) begin
          nxt_mem[c_addr]   <= lifegs_pkg::p2_tag(wk);
          tkn_mem[p2w_addr] <= 1'b1;
        end
      end
      lifegs_pkg::MODE_P3: begin
        if (cmd.step == 4'd0) nxt_q <= nxt_mem[c_addr];
        else cur_mem[c_addr] <= nxt_q;
      end
      default: ;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_tdata[1:0];
      x_in_r <= in_tdata[7:2];
      y_in_r <= in_tdata[13:8];
      ws_r   <= in_tdata[16:14];
    end
    if (cmd.mode == lifegs_pkg::MODE_P1) begin
      if (cmd.step == 4'd0) begin
        cnt_r <= '0;
      end else if (cmd.step == 4'd5) begin
        centre_r <= live_q;
      end else if (cmd.step != lifegs_pkg::P1_LAST) begin
        cnt_r <= n_tot;
      end
    end
    if (cmd.load_out) begin
      out_r <= {2'b00, bad, op_r,
                (op_r == lifegs_pkg::OP_READ && !bad) ? cur_q : lifegs_pkg::CELL_EMPTY};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 7'd64;
      cfg_h_r <= 7'd64;
      cx_r    <= '0;
      cy_r    <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == lifegs_pkg::CFG_WIDTH) cfg_w_r <= cfg_wdata;
      if (cfg_we && cfg_index == lifegs_pkg::CFG_HEIGHT) cfg_h_r <= cfg_wdata;
      if (cmd.mode == lifegs_pkg::MODE_CLR) clr_r <= clr_r + AW'(1);
      if (cmd.cell_rst) begin
        cx_r <= '0;
        cy_r <= '0;
      end else if (cmd.cell_next) begin
        if (cy_r == CW'(effh - DW'(1))) begin
          cy_r <= '0;
          cx_r <= cx_r + CW'(1);
        end else begin
          cy_r <= cy_r + CW'(1);
        end
      end
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/life_grid_step_with_moves.sv -----
// Top level of the toroidal life grid with move tagging.
// Instantiates lifegs_ctrl and lifegs_dp; depends on lifegs_pkg.
//
//  Channel | Direction | Signals                         | Content
//  in_     | input     | in_tvalid, in_tready, in_tdata  | one operation per transaction
//  out_    | output    | out_tvalid, out_tready, out_tdata | one result per operation
//  cfg_    | input     | cfg_we, cfg_index, cfg_wdata    | grid width (0), height (1)
//
// A read or write goes from idle through the operation state to the done state, an unused op straight to done.
// An advance runs the neighbor count (one cell read a cycle), then the source search and
// then the copy back, each pass stepping over every cell of the grid.
// After reset a sweep over all MAX_DIM*MAX_DIM cells clears the grid; no input is taken then.
// The next transaction is taken while a result waits; a result waits for out_tready.
`default_nettype none
module life_grid_step_with_moves #(
  parameter int MAX_DIM = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // op[1:0], cell_x[7:2], cell_y[13:8], write_state[16:14]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // read_state[2:0], done_op[4:3], bad_address[5]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata
);

  lifegs_pkg::cmd_t    cmd;
  lifegs_pkg::status_t sts;

  lifegs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lifegs_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

// ----- sim/life_grid_checker.sv -----
`timescale 1ns / 100ps
// Checker for the life grid block: watches the operation, result and register ports,
// keeps its own copy of the grid and compares every result. Depends on lifegs_pkg.
module life_grid_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam int DIM = 64;

  typedef struct packed {
    logic       bad_address;
    logic [1:0] done_op;
    logic [2:0] read_state;
  } result_t;

  logic [2:0] grid [0:DIM*DIM-1];
  logic [2:0] scratch [0:DIM*DIM-1];
  logic       claimed [0:DIM*DIM-1];
  logic [6:0] width_reg, height_reg;
  result_t    awaited [$];

  function automatic int clamp_dim(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic bit alive(input logic [2:0] s);
    return s == lifegs_pkg::CELL_SURVIVED || s == lifegs_pkg::CELL_BORN ||
           s >= lifegs_pkg::CELL_FROM_XM;
  endfunction

  task automatic step_generation();
    int w, h, n, nx, ny, j;
    int cx [4];
    int cy [4];
    logic [2:0] tags [4];
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    tags = '{lifegs_pkg::CELL_FROM_XM, lifegs_pkg::CELL_FROM_YM,
             lifegs_pkg::CELL_FROM_YP, lifegs_pkg::CELL_FROM_XP};
    foreach (claimed[i]) claimed[i] = 1'b0;
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        n = 0;
        for (int dx = 0; dx < 3; dx++) begin
          for (int dy = 0; dy < 3; dy++) begin
            if (dx == 1 && dy == 1) continue;
            nx = (x + w + dx - 1) % w;
            ny = (y + h + dy - 1) % h;
            if (alive(grid[nx*DIM + ny])) n++;
          end
        end
        if (alive(grid[x*DIM + y]))
          scratch[x*DIM + y] = (n == 2 || n == 3) ? lifegs_pkg::CELL_SURVIVED
                                                  : lifegs_pkg::CELL_DIED;
        else
          scratch[x*DIM + y] = (n == 3) ? lifegs_pkg::CELL_BORN : lifegs_pkg::CELL_EMPTY;
      end
    end
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        if (scratch[x*DIM + y] != lifegs_pkg::CELL_BORN) continue;
        cx[0] = (x + w - 1) % w; cy[0] = y;
        cx[1] = x;               cy[1] = (y + h - 1) % h;
        cx[2] = x;               cy[2] = (y + 1) % h;
        cx[3] = (x + 1) % w;     cy[3] = y;
        for (int k = 0; k < 4; k++) begin
          j = cx[k]*DIM + cy[k];
          if (scratch[j] == lifegs_pkg::CELL_DIED && !claimed[j]) begin
            scratch[x*DIM + y] = tags[k];
            claimed[j] = 1'b1;
            break;
          end
        end
      end
    end
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h; y++)
        grid[x*DIM + y] = scratch[x*DIM + y];
  endtask

  task automatic apply_op(input logic [23:0] d);
    result_t r;
    logic [1:0] op;
    logic [5:0] x, y;
    op = d[1:0];
    x  = d[7:2];
    y  = d[13:8];
    r  = '{read_state: lifegs_pkg::CELL_EMPTY, done_op: op, bad_address: 1'b0};
    if (op == lifegs_pkg::OP_WRITE || op == lifegs_pkg::OP_READ) begin
      if (x >= clamp_dim(width_reg) || y >= clamp_dim(height_reg))
        r.bad_address = 1'b1;
      else if (op == lifegs_pkg::OP_WRITE)
        grid[x*DIM + y] = d[16:14];
      else
        r.read_state = grid[x*DIM + y];
    end else if (op == lifegs_pkg::OP_ADVANCE) begin
      step_generation();
    end
    awaited.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      foreach (grid[i]) grid[i] = lifegs_pkg::CELL_EMPTY;
      width_reg = 7'd64;
      height_reg = 7'd64;
      awaited.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lifegs_pkg::CFG_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == lifegs_pkg::CFG_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) apply_op(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata[5:0];
        if (awaited.size() == 0) begin
          $display("%0t: result expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (got.read_state != want.read_state) begin
            $display("%0t: read_state expected %0d actual %0d", $time,
                     want.read_state, got.read_state);
            fail_count++;
          end
          if (got.done_op != want.done_op) begin
            $display("%0t: done_op expected %0d actual %0d", $time,
                     want.done_op, got.done_op);
            fail_count++;
          end
          if (got.bad_address != want.bad_address) begin
            $display("%0t: bad_address expected %0d actual %0d", $time,
                     want.bad_address, got.bad_address);
            fail_count++;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

// ----- sim/life_grid_step_with_moves_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the life grid block: clock, reset, operation and register stimulus.
// Depends on lifegs_pkg, life_grid_step_with_moves and life_grid_checker.
module life_grid_step_with_moves_tb;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;
  int          fail_count;
  int          pending;
  bit          calm;
  bit          hold_req;
  int          cur_w, cur_h;

  life_grid_step_with_moves uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  life_grid_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver stalls at random and serves one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [5:0] x, input logic [5:0] y,
                         input logic [2:0] ws);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, ws, y, x, op};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_dims(input logic [6:0] w, input logic [6:0] h);
    wait_drained();
    write_reg(lifegs_pkg::CFG_WIDTH, w);
    write_reg(lifegs_pkg::CFG_HEIGHT, h);
    cur_w = (w == 0) ? 1 : (w > 64) ? 64 : int'(w);
    cur_h = (h == 0) ? 1 : (h > 64) ? 64 : int'(h);
    @(posedge clk);
  endtask

  task automatic random_op();
    int r;
    logic [5:0] x, y;
    r = $urandom_range(99);
    x = 6'($urandom_range(cur_w - 1));
    y = 6'($urandom_range(cur_h - 1));
    if (r < 40) begin
      send_op(lifegs_pkg::OP_WRITE, x, y, 3'($urandom_range(7)));
    end else if (r < 62) begin
      send_op(lifegs_pkg::OP_READ, x, y, 3'($urandom_range(7)));
    end else if (r < 75) begin
      if ($urandom_range(1)) x = 6'($urandom_range(63));
      else y = 6'($urandom_range(63));
      send_op(2'($urandom_range(1)), x, y, 3'($urandom_range(7)));
    end else if (r < 95) begin
      send_op(lifegs_pkg::OP_ADVANCE, 6'($urandom_range(63)), 6'($urandom_range(63)),
              3'($urandom_range(7)));
    end else begin
      send_op(OP_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)),
              3'($urandom_range(7)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = lifegs_pkg::CFG_WIDTH;
    cfg_wdata = '0;
    calm      = 1'b1;
    hold_req  = 1'b0;
    cur_w     = 64;
    cur_h     = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Corners of the full grid, an unused op and one full-size generation.
    send_op(lifegs_pkg::OP_WRITE, 6'd0, 6'd0, lifegs_pkg::CELL_FROM_YP);
    send_op(lifegs_pkg::OP_WRITE, 6'd63, 6'd63, lifegs_pkg::CELL_FROM_XP);
    send_op(lifegs_pkg::OP_WRITE, 6'd63, 6'd0, lifegs_pkg::CELL_SURVIVED);
    send_op(lifegs_pkg::OP_WRITE, 6'd0, 6'd63, lifegs_pkg::CELL_BORN);
    send_op(lifegs_pkg::OP_READ, 6'd63, 6'd63, 3'd0);
    send_op(lifegs_pkg::OP_READ, 6'd0, 6'd0, 3'd7);
    send_op(OP_UNUSED, 6'd63, 6'd63, 3'd7);
    send_op(lifegs_pkg::OP_ADVANCE, 6'd0, 6'd0, 3'd0);
    send_op(lifegs_pkg::OP_READ, 6'd0, 6'd0, 3'd0);
    send_op(lifegs_pkg::OP_READ, 6'd63, 6'd0, 3'd0);

    // Zero width acts as one column, oversize height as the full height.
    set_dims(7'd0, 7'd127);
    write_reg(CFG_SPARE, 7'd5);
    send_op(lifegs_pkg::OP_WRITE, 6'd1, 6'd5, lifegs_pkg::CELL_SURVIVED);
    send_op(lifegs_pkg::OP_READ, 6'd0, 6'd63, 3'd0);
    send_op(lifegs_pkg::OP_WRITE, 6'd0, 6'd4, lifegs_pkg::CELL_SURVIVED);
    send_op(lifegs_pkg::OP_WRITE, 6'd0, 6'd5, lifegs_pkg::CELL_SURVIVED);
    send_op(lifegs_pkg::OP_WRITE, 6'd0, 6'd6, lifegs_pkg::CELL_DIED);
    send_op(lifegs_pkg::OP_ADVANCE, 6'd0, 6'd0, 3'd0);
    send_op(lifegs_pkg::OP_READ, 6'd0, 6'd5, 3'd0);

    // Blinker on a small torus, then the grid grows to reveal untouched cells.
    set_dims(7'd5, 7'd5);
    send_op(lifegs_pkg::OP_WRITE, 6'd2, 6'd1, lifegs_pkg::CELL_SURVIVED);
    send_op(lifegs_pkg::OP_WRITE, 6'd2, 6'd2, lifegs_pkg::CELL_FROM_XM);
    send_op(lifegs_pkg::OP_WRITE, 6'd2, 6'd3, lifegs_pkg::CELL_BORN);
    send_op(lifegs_pkg::OP_ADVANCE, 6'd0, 6'd0, 3'd0);
    send_op(lifegs_pkg::OP_READ, 6'd1, 6'd2, 3'd0);
    set_dims(7'd64, 7'd3);
    send_op(lifegs_pkg::OP_READ, 6'd63, 6'd2, 3'd0);

    // Random phases over small grids, a 1x1 grid and a 64x2 grid, each seeded with five random writes.
    calm = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) set_dims(7'd1, 7'd1);
      else if (ph == 5) set_dims(7'd64, 7'd2);
      else set_dims(7'($urandom_range(7, 3)), 7'($urandom_range(7, 3)));
      calm = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 5; i++)
        send_op(lifegs_pkg::OP_WRITE, 6'($urandom_range(cur_w - 1)),
                6'($urandom_range(cur_h - 1)),
                ($urandom_range(3) == 0) ? lifegs_pkg::CELL_EMPTY
                                         : 3'($urandom_range(7, 1)));
      for (int i = 0; i < 6; i++) random_op();
      calm = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lifegs_pkg.sv
rtl/core/lifegs_ctrl.sv
rtl/core/lifegs_dp.sv
rtl/core/life_grid_step_with_moves.sv
sim/life_grid_checker.sv
sim/life_grid_step_with_moves_tb.sv
